### hdl/pidrl_pkg.sv
// Shared types and constants for the PID controller with output ramp limit.
// Used by every module of the block; depends on nothing.
package pidrl_pkg;

	localparam int PIDRL_DATA_WIDTH = 32;
	localparam int PIDRL_FRAC_BITS  = 16;

	localparam int US_PER_SEC      = 1000000;
	localparam int MAX_STEP_US     = 500000;
	localparam int DEFAULT_STEP_US = 1000;
	localparam int DT_W            = 19;  // holds MAX_STEP_US

	localparam int KP_RESET_UNITS = 1;   // 1.0
	localparam int OL_RESET_UNITS = 12;  // 12.0

	// shared divider: 56-bit signed dividend, up to 4e6 divisor
	localparam int DIV_NUM_W          = 56;
	localparam int DIV_DEN_W          = 22;
	localparam int DIV_BITS_PER_CYCLE = 4;
	localparam int DIV_STEPS          = DIV_NUM_W / DIV_BITS_PER_CYCLE;

	typedef enum logic [2:0] {
		CFG_KP,
		CFG_KI,
		CFG_KD,
		CFG_RAMP_RATE,
		CFG_OUTPUT_LIMIT
	} cfg_index_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic signed [31:0] error_sample;
		logic [31:0]        elapsed_us;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] drive_value;
	} drive_t;

	typedef struct packed {
		logic signed [31:0] kp;
		logic signed [31:0] ki;
		logic signed [31:0] kd;
		logic [30:0]        ramp_rate;
		logic [30:0]        output_limit;
	} cfg_regs_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_P,
		OP_MUL_I,
		OP_TRUNC_I,
		OP_MUL_ID,
		OP_DIV_I,
		OP_TRUNC_D,
		OP_MUL_L3,
		OP_LIM3,
		OP_MUL_DD,
		OP_INTEG,
		OP_MUL_R,
		OP_DERIV,
		OP_SUM,
		OP_DIV_R,
		OP_RAMP,
		OP_COMMIT
	} dp_op_t;

	typedef struct packed {
		logic div_busy;
		logic ramp_on;
		logic out_busy;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_I,
		S_TRUNC_I,
		S_MUL_ID,
		S_DIV_I,
		S_TRUNC_D,
		S_MUL_L3,
		S_LIM3,
		S_MUL_DD,
		S_WAIT_I,
		S_INTEG,
		S_MUL_R,
		S_WAIT_D,
		S_DERIV,
		S_SUM,
		S_DIV_R,
		S_WAIT_R,
		S_RAMP,
		S_COMMIT
	} state_t;

endpackage

### hdl/pidrl_chan_if.sv
// Valid/ready channel carrying one payload struct per request.
// Payload type comes from pidrl_pkg at the point of instantiation.
interface pidrl_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/pidrl_cfg.sv
// Configuration register file: gains, ramp rate and output limit.
// Depends on pidrl_pkg and pidrl_chan_if.
module pidrl_cfg import pidrl_pkg::*; #(
	parameter int FRAC_BITS = PIDRL_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	pidrl_chan_if.sink       cfg,
	output cfg_regs_t        regs
);

	localparam logic signed [31:0] KP_RESET = 32'(KP_RESET_UNITS) <<< FRAC_BITS;
	localparam logic [30:0]        OL_RESET = 31'(OL_RESET_UNITS) << FRAC_BITS;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp           <= KP_RESET;
			regs_q.ki           <= '0;
			regs_q.kd           <= '0;
			regs_q.ramp_rate    <= '0;
			regs_q.output_limit <= OL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.data.index))
				CFG_KP:           regs_q.kp           <= cfg.data.value;
				CFG_KI:           regs_q.ki           <= cfg.data.value;
				CFG_KD:           regs_q.kd           <= cfg.data.value;
				CFG_RAMP_RATE:    regs_q.ramp_rate    <= cfg.data.value[30:0];
				CFG_OUTPUT_LIMIT: regs_q.output_limit <= cfg.data.value[30:0];
				default: ;
			endcase
		end
	end

endmodule

### hdl/pidrl_ctrl.sv
// Sequencer for one control step: issues datapath ops, waits on the divider
// and the output register. Depends on pidrl_pkg.
module pidrl_ctrl import pidrl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_ready,
	input  dp_status_t status,
	output dp_op_t     op
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:    if (sample_valid) state_nx = S_MUL_P;
			S_MUL_P:   state_nx = S_MUL_I;
			S_MUL_I:   state_nx = S_TRUNC_I;
			S_TRUNC_I: state_nx = S_MUL_ID;
			S_MUL_ID:  state_nx = S_DIV_I;
			S_DIV_I:   state_nx = S_TRUNC_D;
			S_TRUNC_D: state_nx = S_MUL_L3;
			S_MUL_L3:  state_nx = S_LIM3;
			S_LIM3:    state_nx = S_MUL_DD;
			S_MUL_DD:  state_nx = S_WAIT_I;
			S_WAIT_I:  if (!status.div_busy) state_nx = S_INTEG;
			S_INTEG:   state_nx = status.ramp_on ? S_MUL_R : S_WAIT_D;
			S_MUL_R:   state_nx = S_WAIT_D;
			S_WAIT_D:  if (!status.div_busy) state_nx = S_DERIV;
			S_DERIV:   state_nx = S_SUM;
			S_SUM:     state_nx = status.ramp_on ? S_DIV_R : S_COMMIT;
			S_DIV_R:   state_nx = S_WAIT_R;
			S_WAIT_R:  if (!status.div_busy) state_nx = S_RAMP;
			S_RAMP:    state_nx = S_COMMIT;
			S_COMMIT:  if (!status.out_busy) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		sample_ready = 1'b0;
		op           = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) op = OP_LOAD;
			end
			S_MUL_P:   op = OP_MUL_P;
			S_MUL_I:   op = OP_MUL_I;
			S_TRUNC_I: op = OP_TRUNC_I;
			S_MUL_ID:  op = OP_MUL_ID;
			S_DIV_I:   op = OP_DIV_I;
			S_TRUNC_D: op = OP_TRUNC_D;
			S_MUL_L3:  op = OP_MUL_L3;
			S_LIM3:    op = OP_LIM3;
			S_MUL_DD:  op = OP_MUL_DD;
			S_WAIT_I:  op = OP_NONE;
			S_INTEG:   op = OP_INTEG;
			S_MUL_R:   op = OP_MUL_R;
			S_WAIT_D:  op = OP_NONE;
			S_DERIV:   op = OP_DERIV;
			S_SUM:     op = OP_SUM;
			S_DIV_R:   op = OP_DIV_R;
			S_WAIT_R:  op = OP_NONE;
			S_RAMP:    op = OP_RAMP;
			S_COMMIT:  if (!status.out_busy) op = OP_COMMIT;
			default:   op = OP_NONE;
		endcase
	end

endmodule

### hdl/pidrl_div.sv
// Iterative signed-by-unsigned floor divider, several quotient bits a cycle.
// Depends on pidrl_pkg.
module pidrl_div import pidrl_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0]        den,
	output logic                        busy,
	output logic signed [DIV_NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic                        busy_q, fix_q, neg_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [DIV_NUM_W-1:0]        mag_q, mag_nx, num_mag;
	logic [DIV_DEN_W:0]          rem_q, rem_nx;
	logic [DIV_DEN_W-1:0]        den_q;
	logic signed [DIV_NUM_W-1:0] quot_q;
	logic [DIV_NUM_W-1:0]        q_up;

	assign busy    = busy_q;
	assign quot    = quot_q;
	assign num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);

	// restoring steps; quotient bits shift into the dividend register
	always_comb begin
		rem_nx = rem_q;
		mag_nx = mag_q;
		for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
			rem_nx = {rem_nx[DIV_DEN_W-1:0], mag_nx[DIV_NUM_W-1]};
			mag_nx = {mag_nx[DIV_NUM_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, den_q}) begin
				rem_nx    = rem_nx - {1'b0, den_q};
				mag_nx[0] = 1'b1;
			end
		end
	end

	// negative dividend: floor means rounding the magnitude up on a remainder
	assign q_up = mag_q + DIV_NUM_W'(rem_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (fix_q) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) fix_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[DIV_NUM_W-1];
		end else if (busy_q) begin
			if (fix_q) begin
				quot_q <= neg_q ? -$signed(q_up) : $signed(mag_q);
			end else begin
				mag_q <= mag_nx;
				rem_q <= rem_nx;
			end
		end
	end

endmodule

### hdl/pidrl_dp.sv
// Datapath: shared multiplier, divider, term registers, controller state and
// the output register. Depends on pidrl_pkg and pidrl_div.
module pidrl_dp import pidrl_pkg::*; #(
	parameter int DATA_WIDTH = PIDRL_DATA_WIDTH,
	parameter int FRAC_BITS  = PIDRL_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_op_t     op,
	output dp_status_t status,
	input  cfg_regs_t  regs,
	input  sample_t    sample,
	input  logic       drive_ready,
	output logic       drive_valid,
	output drive_t     drive
);

	localparam int WW = ((DATA_WIDTH + 3) > DIV_NUM_W) ? (DATA_WIDTH + 3) : DIV_NUM_W;

	localparam logic signed [WW-1:0] ONE_W  = 1;
	localparam logic signed [WW-1:0] DW_MAX = (ONE_W <<< (DATA_WIDTH - 1)) - ONE_W;
	localparam logic signed [WW-1:0] DW_MIN = -DW_MAX - ONE_W;

	localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	localparam logic signed [32:0] RECIP3  = 33'sh0AAAAAAAB;  // x/3 = x*RECIP3 >> 33
	localparam logic signed [32:0] USEC_33 = 33'(US_PER_SEC);
	localparam logic signed [63:0] USEC_64 = 64'(US_PER_SEC);

	function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [WW-1:0] v);
		logic signed [WW-1:0] r;
		if (v > DW_MAX)      r = DW_MAX;
		else if (v < DW_MIN) r = DW_MIN;
		else                 r = v;
		return r[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [WW-1:0] ext_dw(input logic signed [DATA_WIDTH-1:0] v);
		return WW'(v);
	endfunction

	function automatic logic signed [31:0] qround32(input logic signed [63:0] p);
		logic signed [63:0] r;
		r = (p + HALF) >>> FRAC_BITS;
		if (r > S32_MAX)      r = S32_MAX;
		else if (r < S32_MIN) r = S32_MIN;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [32:0] r;
		if (v > 33'sd2147483647)       r = 33'sd2147483647;
		else if (v < -33'sd2147483648) r = -33'sd2147483648;
		else                           r = v;
		return r[31:0];
	endfunction

	// per-step payload
	logic signed [31:0]           err_q, t_q;
	logic [DT_W-1:0]              dt_q, dt_fix;
	logic signed [63:0]           prod_q;
	logic [30:0]                  lim3_q;
	logic signed [DATA_WIDTH-1:0] prop_q, integ_q, deriv_q, sum_q;
	drive_t                       drive_q;

	// controller state
	logic signed [31:0]           last_err_q;
	logic signed [DATA_WIDTH-1:0] last_int_q, last_out_q;
	logic                         out_valid_q;

	logic signed [32:0]           mul_a, mul_b;
	logic signed [65:0]           mul_p;
	logic                         mul_en;
	logic signed [31:0]           err_sum, err_dif;

	logic                         div_start, div_busy;
	logic signed [DIV_NUM_W-1:0]  div_num, div_quot;
	logic [DIV_DEN_W-1:0]         div_den;
	logic signed [63:0]           num_wide;

	logic signed [DATA_WIDTH-1:0] integ_nx, sum_nx, ramp_nx;
	logic signed [WW-1:0]         sum_w;

	assign err_sum = sat32({err_q[31], err_q} + {last_err_q[31], last_err_q});
	assign err_dif = sat32({err_q[31], err_q} - {last_err_q[31], last_err_q});

	assign dt_fix = (sample.elapsed_us == '0 || sample.elapsed_us > 32'(MAX_STEP_US))
		? DT_W'(DEFAULT_STEP_US) : sample.elapsed_us[DT_W-1:0];

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (op)
			OP_MUL_P:  begin mul_a = 33'(regs.kp); mul_b = 33'(err_q); end
			OP_MUL_I:  begin mul_a = 33'(regs.ki); mul_b = 33'(err_sum); end
			OP_MUL_ID: begin mul_a = 33'(t_q); mul_b = $signed({14'b0, dt_q}); end
			OP_DIV_I:  begin mul_a = 33'(regs.kd); mul_b = 33'(err_dif); end
			OP_MUL_L3: begin mul_a = $signed({2'b0, regs.output_limit}); mul_b = RECIP3; end
			OP_MUL_DD: begin mul_a = 33'(t_q); mul_b = USEC_33; end
			OP_MUL_R:  begin mul_a = $signed({2'b0, regs.ramp_rate}); mul_b = $signed({14'b0, dt_q}); end
			default:   mul_en = 1'b0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// round_div(n, d) is floor((2n + d) / 2d)
	always_comb begin
		div_start = 1'b1;
		num_wide  = '0;
		div_den   = '0;
		unique case (op)
			OP_DIV_I: begin
				num_wide = (prod_q <<< 1) + 2 * USEC_64;
				div_den  = DIV_DEN_W'(4 * US_PER_SEC);
			end
			OP_INTEG: begin
				num_wide = (prod_q <<< 1) + $signed({45'b0, dt_q});
				div_den  = DIV_DEN_W'({dt_q, 1'b0});
			end
			OP_DIV_R: begin
				num_wide = (prod_q <<< 1) + USEC_64;
				div_den  = DIV_DEN_W'(2 * US_PER_SEC);
			end
			default: div_start = 1'b0;
		endcase
		div_num = num_wide[DIV_NUM_W-1:0];
	end

	pidrl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		logic signed [WW-1:0] i_w, s_w, lim_w, ol_w, step_w, diff_w, lo_w;
		lim_w  = WW'($signed({1'b0, lim3_q}));
		ol_w   = WW'($signed({1'b0, regs.output_limit}));
		step_w = WW'(div_quot);
		lo_w   = ext_dw(last_out_q);

		// integral: accumulate, saturate, clamp to a third of the limit
		i_w = ext_dw(sat_dw(ext_dw(last_int_q) + ext_dw(sat_dw(step_w))));
		if (i_w > lim_w)       i_w = lim_w;
		else if (i_w < -lim_w) i_w = -lim_w;
		integ_nx = i_w[DATA_WIDTH-1:0];

		s_w = ext_dw(sat_dw(ext_dw(prop_q) + ext_dw(integ_q) + ext_dw(deriv_q)));
		if (s_w > ol_w)       s_w = ol_w;
		else if (s_w < -ol_w) s_w = -ol_w;
		sum_nx = s_w[DATA_WIDTH-1:0];

		diff_w = ext_dw(sum_q) - lo_w;
		if (diff_w > step_w)       ramp_nx = sat_dw(lo_w + step_w);
		else if (diff_w < -step_w) ramp_nx = sat_dw(lo_w - step_w);
		else                       ramp_nx = sum_q;
	end

	assign sum_w = ext_dw(sum_q);

	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= mul_p[63:0];
		unique case (op)
			OP_LOAD: begin
				err_q <= sample.error_sample;
				dt_q  <= dt_fix;
			end
			OP_MUL_I:   prop_q   <= sat_dw(WW'(qround32(prod_q)));
			OP_TRUNC_I: t_q      <= qround32(prod_q);
			OP_TRUNC_D: t_q      <= qround32(prod_q);
			OP_LIM3:    lim3_q   <= prod_q[63:33];
			OP_INTEG:   integ_q  <= integ_nx;
			OP_DERIV:   deriv_q  <= sat_dw(WW'(div_quot));
			OP_SUM:     sum_q    <= sum_nx;
			OP_RAMP:    sum_q    <= ramp_nx;
			OP_COMMIT:  drive_q.drive_value <= sum_w[31:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q  <= '0;
			last_int_q  <= '0;
			last_out_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == OP_COMMIT) begin
				last_err_q  <= err_q;
				last_int_q  <= integ_q;
				last_out_q  <= sum_q;
				out_valid_q <= 1'b1;
			end else if (drive_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.div_busy = div_busy;
	assign status.ramp_on  = (regs.ramp_rate != '0);
	assign status.out_busy = out_valid_q && !drive_ready;

	assign drive_valid = out_valid_q;
	assign drive       = drive_q;

endmodule

### hdl/pid_with_ramp_limit.sv
// PID controller with trapezoid integral, anti-windup and output ramp limit.
// Depends on pidrl_pkg, pidrl_chan_if, pidrl_cfg, pidrl_ctrl and pidrl_dp.
//
// Channels: cfg takes register writes (index, value) and is always ready;
// write only while no request is in flight. samples takes one error sample
// and its elapsed time per request; drives returns one output per request.
// The time from sample acceptance to drive valid is longer with the ramp
// limit on, which adds a third divide and a ramp multiply; the next sample can
// be taken the cycle after the result is written to the output register. That
// time is set by the shared divider (56 dividend bits, 4 per cycle, plus a
// sign fix step) run two or three times in a row, and the single shared
// multiplier.
// A finished result sits in the output register while the next sample is
// accepted and worked on; if drives is still stalled when that next result
// is ready, the sequencer holds it until the register is taken.
// Reset clears the stored error, integral and output, and loads the
// default gains (kp of one, ki and kd zero, ramp off, limit of twelve).
module pid_with_ramp_limit import pidrl_pkg::*; #(
	parameter int DATA_WIDTH = PIDRL_DATA_WIDTH,
	parameter int FRAC_BITS  = PIDRL_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	pidrl_chan_if.sink   cfg,
	pidrl_chan_if.sink   samples,
	pidrl_chan_if.source drives
);

	cfg_regs_t  regs;
	dp_status_t status;
	dp_op_t     op;
	sample_t    sample;
	drive_t     drive;
	logic       drive_valid;
	logic       sample_ready;

	assign sample        = samples.data;
	assign samples.ready = sample_ready;
	assign drives.valid  = drive_valid;
	assign drives.data   = drive;

	pidrl_cfg #(
		.FRAC_BITS (FRAC_BITS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pidrl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples.valid),
		.sample_ready (sample_ready),
		.status       (status),
		.op           (op)
	);

	pidrl_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.status      (status),
		.regs        (regs),
		.sample      (sample),
		.drive_ready (drives.ready),
		.drive_valid (drive_valid),
		.drive       (drive)
	);

endmodule
